// ===== design/tmau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmau_pkg
// Shared types, constants and control records of the topic message update.
// ----------------------------------------------------------------------------
package tmau_pkg;

  // Default sizes of the tables.
  localparam int TOPICS_DEF      = 16;
  localparam int VOCAB_DEF       = 1024;
  localparam int DOCS_DEF        = 256;
  localparam int TOKEN_SLOTS_DEF = 4096;

  // Fixed field and arithmetic widths.
  localparam int CFG_W     = 32;
  localparam int TOPIC_W   = 4;
  localparam int MSG_W     = 17;
  localparam int DIV_NW    = 49;
  localparam int DIV_DW    = 41;
  localparam int DIV_CNT_W = 6;

  localparam logic [MSG_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [31:0]      MAX32   = 32'hFFFF_FFFF;
  localparam logic [35:0]      MAX36   = 36'hF_FFFF_FFFF;
  localparam logic [39:0]      MAX40   = 40'hFF_FFFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ALPHA      = 2'd0,
    CFG_BETA       = 2'd1,
    CFG_VOCAB_BETA = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_UPDATE = 1'b1
  } opcode_e;

  typedef struct packed {
    logic       opcode;
    logic [9:0] word_index;
    logic [7:0] doc_index;
    logic [11:0] token_slot;
    logic [7:0] count;
    logic [3:0] initial_topic;
  } in_item_t;

  typedef struct packed {
    logic [TOPIC_W-1:0] topic;
    logic [MSG_W-1:0]   message;
    logic               last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic ld_wr;
    logic msg_wr;
    logic p1_sub;
    logic div_start;
    logic div_norm;
    logic ratio_load;
    logic mul;
    logic acc;
    logic p2_wb;
    logic k_inc;
    logic k_zero;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic in_ok;
    logic in_op;
    logic k_last;
    logic div_done;
    logic out_free;
  } status_t;

  typedef enum logic [12:0] {
    ST_CLEAR   = 13'b0000000000001,
    ST_IDLE    = 13'b0000000000010,
    ST_LD_RD   = 13'b0000000000100,
    ST_LD_WR   = 13'b0000000001000,
    ST_LD_MSG  = 13'b0000000010000,
    ST_P1_RD   = 13'b0000000100000,
    ST_P1_SUB  = 13'b0000001000000,
    ST_P1_DIV  = 13'b0000010000000,
    ST_P1_WAIT = 13'b0000100000000,
    ST_P1_MUL  = 13'b0001000000000,
    ST_P1_ACC  = 13'b0010000000000,
    ST_P2_DIV  = 13'b0100000000000,
    ST_P2_WAIT = 13'b1000000000000
  } state_e;

endpackage

// ===== design/topic_message_async_update_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topic_message_async_update_top
// Per-token topic message update with count tables and normalized messages.
// ----------------------------------------------------------------------------
// Load item: tables read, count written, one message set per topic. Update item:
// the bit-serial divider (49 steps) is used twice per topic.
// One item is in work at a time; results leave through a one-beat register.
// After reset the word and document tables are cleared; no item is taken meanwhile.
// Reset is asynchronous and active low; configuration returns to defaults.
module topic_message_async_update_top #(
  parameter int TOPICS      = tmau_pkg::TOPICS_DEF,
  parameter int VOCAB       = tmau_pkg::VOCAB_DEF,
  parameter int DOCS        = tmau_pkg::DOCS_DEF,
  parameter int TOKEN_SLOTS = tmau_pkg::TOKEN_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tmau_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tmau_pkg::out_item_t         out_data_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [tmau_pkg::CFG_W-1:0]  cfg_data_i
);

  import tmau_pkg::*;

  cmd_t    cmd;
  status_t status;

  tmau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tmau_dp #(
    .TOPICS      (TOPICS),
    .VOCAB       (VOCAB),
    .DOCS        (DOCS),
    .TOKEN_SLOTS (TOKEN_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // No item is taken while the tables are still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> status.clr_done)
    else $error("item accepted during table clearing");

  // A new result never overwrites a beat that is still waiting.
  a_no_out_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.p2_wb |-> status.out_free)
    else $error("result register overwritten");

  // The divider is only started when it is idle.
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> status.div_done)
    else $error("divider restarted while busy");

endmodule

// ===== design/tmau_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmau_div
// Restoring divider, one quotient bit per cycle, shared by both passes.
// ----------------------------------------------------------------------------
module tmau_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tmau_pkg::DIV_NW-1:0]  dividend_i,
  input  logic [tmau_pkg::DIV_DW-1:0]  divisor_i,
  output logic                         done_o,
  output logic [tmau_pkg::DIV_NW-1:0]  quotient_o
);

  import tmau_pkg::*;

  logic [DIV_DW:0]    rem_q, rem_d, trial;
  logic [DIV_NW-1:0]  quo_q, quo_d;
  logic [DIV_DW-1:0]  dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic               bit_set;

  // One shift and trial subtraction per cycle.
  always_comb begin
    trial   = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
    bit_set = (trial >= {1'b0, dvs_q});
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = DIV_CNT_W'(DIV_NW);
    end else if (cnt_q != '0) begin
      rem_d = bit_set ? (trial - {1'b0, dvs_q}) : trial;
      quo_d = {quo_q[DIV_NW-2:0], bit_set};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = (cnt_q == '0);
  assign quotient_o = quo_q;

endmodule

// ===== design/tmau_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmau_ctrl
// Sequencer for load and update items; drives the datapath by commands.
// ----------------------------------------------------------------------------
module tmau_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tmau_pkg::status_t  status_i,
  output tmau_pkg::cmd_t     cmd_o
);

  import tmau_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.latch_in = 1'b1;
          if (!status_i.in_ok) state_d = ST_IDLE;
          else if (status_i.in_op == OP_LOAD) state_d = ST_LD_RD;
          else state_d = ST_P1_RD;
        end
      end
      ST_LD_RD: state_d = ST_LD_WR;
      ST_LD_WR: begin
        cmd_o.ld_wr  = 1'b1;
        cmd_o.k_zero = 1'b1;
        state_d      = ST_LD_MSG;
      end
      ST_LD_MSG: begin
        cmd_o.msg_wr = 1'b1;
        cmd_o.k_inc  = 1'b1;
        if (status_i.k_last) state_d = ST_IDLE;
      end
      ST_P1_RD: state_d = ST_P1_SUB;
      ST_P1_SUB: begin
        cmd_o.p1_sub = 1'b1;
        state_d      = ST_P1_DIV;
      end
      ST_P1_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_P1_WAIT;
      end
      ST_P1_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.ratio_load = 1'b1;
          state_d          = ST_P1_MUL;
        end
      end
      ST_P1_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_P1_ACC;
      end
      ST_P1_ACC: begin
        cmd_o.acc = 1'b1;
        if (status_i.k_last) begin
          cmd_o.k_zero = 1'b1;
          state_d      = ST_P2_DIV;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_P1_RD;
        end
      end
      ST_P2_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_norm  = 1'b1;
        state_d         = ST_P2_WAIT;
      end
      ST_P2_WAIT: begin
        cmd_o.div_norm = 1'b1;
        if (status_i.div_done && status_i.out_free) begin
          cmd_o.p2_wb = 1'b1;
          cmd_o.k_inc = 1'b1;
          state_d     = status_i.k_last ? ST_IDLE : ST_P2_DIV;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/tmau_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmau_dp
// Datapath: count tables, message store, weight arithmetic and result beat.
// ----------------------------------------------------------------------------
module tmau_dp #(
  parameter int TOPICS      = tmau_pkg::TOPICS_DEF,
  parameter int VOCAB       = tmau_pkg::VOCAB_DEF,
  parameter int DOCS        = tmau_pkg::DOCS_DEF,
  parameter int TOKEN_SLOTS = tmau_pkg::TOKEN_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tmau_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tmau_pkg::out_item_t         out_data_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [tmau_pkg::CFG_W-1:0]  cfg_data_i,
  input  tmau_pkg::cmd_t              cmd_i,
  output tmau_pkg::status_t           status_o
);

  import tmau_pkg::*;

  localparam int KW    = $clog2(TOPICS);
  localparam int WN    = VOCAB * TOPICS;
  localparam int DN    = DOCS * TOPICS;
  localparam int MN    = TOKEN_SLOTS * TOPICS;
  localparam int WAW   = (WN > 1) ? $clog2(WN) : 1;
  localparam int DAW   = (DN > 1) ? $clog2(DN) : 1;
  localparam int MAW   = (MN > 1) ? $clog2(MN) : 1;
  localparam int CLR_N = ((VOCAB > DOCS) ? VOCAB : DOCS) * TOPICS;
  localparam int CW    = $clog2(CLR_N + 1);

  // Configuration registers.
  logic [31:0] alpha_q, beta_q, vbeta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 32'd32768;
      beta_q  <= 32'd655;
      vbeta_q <= 32'd670720;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALPHA:      alpha_q <= cfg_data_i;
        CFG_BETA:       beta_q  <= cfg_data_i;
        CFG_VOCAB_BETA: vbeta_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Latched item and topic counter.
  in_item_t item_q;
  logic [KW-1:0] k_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) item_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.latch_in) begin
      k_q <= (in_data_i.opcode == OP_LOAD) ? KW'(in_data_i.initial_topic) : '0;
    end else if (cmd_i.k_zero) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + 1'b1;
    end
  end

  // Post-reset clearing sweep of the word and document tables.
  logic [CW-1:0] clr_q;
  logic          clearing;

  assign clearing = (clr_q != CW'(CLR_N));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Table addresses of the current topic.
  logic [WAW-1:0] wt_addr;
  logic [DAW-1:0] dt_addr;
  logic [MAW-1:0] msg_addr;

  assign wt_addr  = WAW'(item_q.word_index) * WAW'(TOPICS) + WAW'(k_q);
  assign dt_addr  = DAW'(item_q.doc_index) * DAW'(TOPICS) + DAW'(k_q);
  assign msg_addr = MAW'(item_q.token_slot) * MAW'(TOPICS) + MAW'(k_q);

  // Memories and the topic totals.
  logic [31:0]      wt_mem [WN];
  logic [31:0]      dt_mem [DN];
  logic [MSG_W-1:0] msg_mem [MN];
  logic [39:0]      tt_q [TOPICS];
  logic [31:0]      wt_rd_q, dt_rd_q;
  logic [MSG_W-1:0] msg_rd_q;

  logic             tbl_we, msg_we;
  logic [31:0]      wt_wdata, dt_wdata;
  logic [39:0]      tt_wdata;
  logic [MSG_W-1:0] msg_wdata;

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      if (clr_q < CW'(WN)) wt_mem[WAW'(clr_q)] <= '0;
    end else if (tbl_we) begin
      wt_mem[wt_addr] <= wt_wdata;
    end
    wt_rd_q <= wt_mem[wt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      if (clr_q < CW'(DN)) dt_mem[DAW'(clr_q)] <= '0;
    end else if (tbl_we) begin
      dt_mem[dt_addr] <= dt_wdata;
    end
    dt_rd_q <= dt_mem[dt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (msg_we) msg_mem[msg_addr] <= msg_wdata;
    msg_rd_q <= msg_mem[msg_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TOPICS; i++) tt_q[i] <= '0;
    end else if (tbl_we) begin
      tt_q[k_q] <= tt_wdata;
    end
  end

  // Arithmetic registers.
  logic [32:0]  num_q, doca_q;
  logic [40:0]  den_q;
  logic [31:0]  ratio_q;
  logic [48:0]  phi_q;
  logic [47:0]  plo_q;
  logic [31:0]  weights_q [TOPICS];
  logic [35:0]  sum_q;

  logic [24:0]  c_sub, c_add;
  logic [23:0]  c_load;
  logic [31:0]  wt_sub, dt_sub;
  logic [39:0]  tt_sub;
  logic [32:0]  wt_sum, dt_sum;
  logic [40:0]  tt_sum;
  logic [49:0]  w_full;
  logic [31:0]  w_sat;
  logic [36:0]  s_full;
  logic [MSG_W-1:0] m_val;
  logic [DIV_NW-1:0] quo;
  logic         div_done;

  // Removal of the old contribution, floored at zero.
  assign c_sub  = 25'(item_q.count) * 25'(msg_rd_q);
  assign wt_sub = (wt_rd_q > 32'(c_sub)) ? (wt_rd_q - 32'(c_sub)) : '0;
  assign dt_sub = (dt_rd_q > 32'(c_sub)) ? (dt_rd_q - 32'(c_sub)) : '0;
  assign tt_sub = (tt_q[k_q] > 40'(c_sub)) ? (tt_q[k_q] - 40'(c_sub)) : '0;

  // New message from the normalizing division.
  always_comb begin
    if (sum_q == '0) m_val = '0;
    else if (quo > DIV_NW'(ONE_Q16)) m_val = ONE_Q16;
    else m_val = quo[MSG_W-1:0];
  end

  // Added contribution: the load count or count times the new message.
  assign c_load = {item_q.count, 16'h0000};
  assign c_add  = cmd_i.ld_wr ? 25'(c_load) : (25'(item_q.count) * 25'(m_val));
  assign wt_sum = {1'b0, wt_rd_q} + 33'(c_add);
  assign dt_sum = {1'b0, dt_rd_q} + 33'(c_add);
  assign tt_sum = {1'b0, tt_q[k_q]} + 41'(c_add);

  // Table write selection.
  always_comb begin
    tbl_we   = cmd_i.ld_wr || cmd_i.p1_sub || cmd_i.p2_wb;
    wt_wdata = wt_sub;
    dt_wdata = dt_sub;
    tt_wdata = tt_sub;
    if (!cmd_i.p1_sub) begin
      wt_wdata = wt_sum[32] ? MAX32 : wt_sum[31:0];
      dt_wdata = dt_sum[32] ? MAX32 : dt_sum[31:0];
      tt_wdata = tt_sum[40] ? MAX40 : tt_sum[39:0];
    end
    msg_we    = cmd_i.msg_wr || cmd_i.p2_wb;
    msg_wdata = cmd_i.msg_wr
              ? ((k_q == KW'(item_q.initial_topic)) ? ONE_Q16 : '0)
              : m_val;
  end

  // Shared divider: the ratio in the first pass, the message in the second.
  logic [DIV_NW-1:0] dividend;
  logic [DIV_DW-1:0] divisor;

  assign dividend = cmd_i.div_norm ? DIV_NW'({weights_q[k_q], 16'h0000})
                                   : {num_q, 16'h0000};
  assign divisor  = cmd_i.div_norm ? DIV_DW'(sum_q) : den_q;

  tmau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Weight product, split in two partial products, then saturated.
  assign w_full = 50'(phi_q) + 50'(plo_q[47:16]);
  assign w_sat  = (w_full > 50'(MAX32)) ? MAX32 : w_full[31:0];
  assign s_full = 37'(sum_q) + 37'(w_sat);

  always_ff @(posedge clk_i) begin
    if (cmd_i.p1_sub) begin
      num_q  <= {1'b0, wt_sub} + {1'b0, beta_q};
      doca_q <= {1'b0, dt_sub} + {1'b0, alpha_q};
      den_q  <= {1'b0, tt_sub} + 41'(vbeta_q);
    end
    if (cmd_i.ratio_load) begin
      ratio_q <= (quo > DIV_NW'(MAX32)) ? MAX32 : quo[31:0];
    end
    if (cmd_i.mul) begin
      phi_q <= 49'(ratio_q) * 49'(doca_q[32:16]);
      plo_q <= 48'(ratio_q) * 48'(doca_q[15:0]);
    end
    if (cmd_i.acc) weights_q[k_q] <= w_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (cmd_i.latch_in) begin
      sum_q <= '0;
    end else if (cmd_i.acc) begin
      sum_q <= (s_full > 37'(MAX36)) ? MAX36 : s_full[35:0];
    end
  end

  // Result register.
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.p2_wb) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.p2_wb) begin
      out_q.topic   <= TOPIC_W'(k_q);
      out_q.message <= m_val;
      out_q.last    <= (k_q == KW'(TOPICS - 1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status back to the controller.
  always_comb begin
    status_o.clr_done = !clearing;
    status_o.in_ok    = (32'(in_data_i.word_index) < 32'(VOCAB))
                     && (32'(in_data_i.doc_index) < 32'(DOCS))
                     && (32'(in_data_i.token_slot) < 32'(TOKEN_SLOTS))
                     && ((in_data_i.opcode == OP_UPDATE)
                         || (32'(in_data_i.initial_topic) < 32'(TOPICS)));
    status_o.in_op    = in_data_i.opcode;
    status_o.k_last   = (k_q == KW'(TOPICS - 1));
    status_o.div_done = div_done;
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

endmodule
